// ===== rtl/core/bdlp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdlp_pkg
// shared types and constants of the button debouncer with long press
// ----------------------------------------------------------------------------
package bdlp_pkg;

	// fixed field widths
	localparam int NUM_BUTTONS     = 4;
	localparam int DB_TICKS_WIDTH  = 8;
	localparam int LONG_TICKS_WIDTH = 16;
	localparam int CFG_INDEX_WIDTH = 8;
	localparam int CFG_DATA_WIDTH  = 16;
	localparam int S_TDATA_WIDTH   = 8;
	localparam int M_TDATA_WIDTH   = 16;

	// default storage widths
	localparam int DEF_DEBOUNCE_WIDTH = 8;
	localparam int DEF_HOLD_WIDTH     = 16;

	// register indexes
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_DEBOUNCE_TICKS     = 8'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_LONG_TICKS         = 8'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_LONG_ENABLE_MASK   = 8'd2;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_REPEAT_ENABLE_MASK = 8'd3;

	// reset values
	localparam logic [DB_TICKS_WIDTH-1:0]   RST_DEBOUNCE_TICKS     = 8'd5;
	localparam logic [LONG_TICKS_WIDTH-1:0] RST_LONG_TICKS         = 16'd1000;
	localparam logic [NUM_BUTTONS-1:0]      RST_LONG_ENABLE_MASK   = 4'd7;
	localparam logic [NUM_BUTTONS-1:0]      RST_REPEAT_ENABLE_MASK = 4'd6;

	// settings seen by one button
	typedef struct packed {
		logic [DB_TICKS_WIDTH-1:0]   debounce_ticks;
		logic [LONG_TICKS_WIDTH-1:0] long_ticks;
		logic                        long_en;
		logic                        repeat_en;
	} bdlp_cfg_t;

	// events of one button for one tick
	typedef struct packed {
		logic press_hit;
		logic long_hit;
		logic repeat_hit;
	} bdlp_ev_t;

endpackage

// ===== rtl/core/button_debounce_long_press.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_debounce_long_press
// four-button integrating debouncer with long-press and repeat events
// ----------------------------------------------------------------------------
// usage:
//   s_* stream: one transfer is one sampling tick, s_tdata[3:0] holds one
//     active-high level per button
//   m_* stream: exactly one transfer per tick with press, long and repeat
//     event bits for every button
//   cfg_* channel: register writes, always ready, issued while idle
// pipeline: a tick is held in the input register, and its events in the
//   result register, which offers them on the m_* stream
// throughput: one tick per cycle unless stalled; the per-button counters
//   update in a single pass between the input and result registers
// reset: counters, flags and valid bits clear, registers take their
//   defaults (debounce 5, long 1000, long mask 7, repeat mask 6)
// stall: while m_tready is low the result register holds and an empty
//   input register still takes one more tick; then s_tready drops until
//   the result is taken
// ----------------------------------------------------------------------------
module button_debounce_long_press
	import bdlp_pkg::*;
#(
	parameter int DEBOUNCE_WIDTH = DEF_DEBOUNCE_WIDTH,
	parameter int HOLD_WIDTH     = DEF_HOLD_WIDTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// input stream
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [S_TDATA_WIDTH-1:0]   s_tdata,   // [3:0] pin_levels, rest zero
	// result stream
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [M_TDATA_WIDTH-1:0]   m_tdata,   // [3:0] press_events,
	                                              // [7:4] long_events,
	                                              // [11:8] repeat_events, rest zero
	// configuration writes
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

	logic [DB_TICKS_WIDTH-1:0]   debounce_ticks_q;
	logic [LONG_TICKS_WIDTH-1:0] long_ticks_q;
	logic [NUM_BUTTONS-1:0]      long_mask_q;
	logic [NUM_BUTTONS-1:0]      repeat_mask_q;

	logic                        valid_s1;
	logic [NUM_BUTTONS-1:0]      pins_s1;
	logic                        advance;

	bdlp_ev_t                    ev [NUM_BUTTONS];
	logic [NUM_BUTTONS-1:0]      press_ev, long_ev, repeat_ev;
	logic [M_TDATA_WIDTH-1:0]    result_q;
	logic                        result_valid_q;

	// configuration registers, writes are never stalled
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_ticks_q <= RST_DEBOUNCE_TICKS;
			long_ticks_q     <= RST_LONG_TICKS;
			long_mask_q      <= RST_LONG_ENABLE_MASK;
			repeat_mask_q    <= RST_REPEAT_ENABLE_MASK;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_DEBOUNCE_TICKS: begin
					debounce_ticks_q <= cfg_data[DB_TICKS_WIDTH-1:0];
				end
				REG_LONG_TICKS: begin
					long_ticks_q <= cfg_data[LONG_TICKS_WIDTH-1:0];
				end
				REG_LONG_ENABLE_MASK: begin
					long_mask_q <= cfg_data[NUM_BUTTONS-1:0];
				end
				REG_REPEAT_ENABLE_MASK: begin
					repeat_mask_q <= cfg_data[NUM_BUTTONS-1:0];
				end
				default: begin
					// unknown index, write dropped
				end
			endcase
		end
	end

	// the tick in the input register moves on whenever the result slot is
	// free or is being emptied in this cycle
	assign advance  = !result_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// payload register, no reset needed
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			pins_s1 <= s_tdata[NUM_BUTTONS-1:0];
		end
	end

	// one cell per button, state advances once per tick
	for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_btn
		bdlp_cfg_t cell_cfg;

		assign cell_cfg.debounce_ticks = debounce_ticks_q;
		assign cell_cfg.long_ticks     = long_ticks_q;
		assign cell_cfg.long_en        = long_mask_q[i];
		assign cell_cfg.repeat_en      = repeat_mask_q[i];

		bdlp_cell #(
			.DEBOUNCE_WIDTH (DEBOUNCE_WIDTH),
			.HOLD_WIDTH     (HOLD_WIDTH)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.step   (valid_s1 && advance),
			.pin    (pins_s1[i]),
			.cfg    (cell_cfg),
			.ev     (ev[i])
		);

		assign press_ev[i]  = ev[i].press_hit;
		assign long_ev[i]   = ev[i].long_hit;
		assign repeat_ev[i] = ev[i].repeat_hit;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			result_q <= M_TDATA_WIDTH'({repeat_ev, long_ev, press_ev});
		end
	end

	assign m_tvalid = result_valid_q;
	assign m_tdata  = result_q;

endmodule

// ===== rtl/core/bdlp_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdlp_cell
// per-button integrating debounce, hold counter and event decode
// ----------------------------------------------------------------------------
module bdlp_cell
	import bdlp_pkg::*;
#(
	parameter int DEBOUNCE_WIDTH = DEF_DEBOUNCE_WIDTH,
	parameter int HOLD_WIDTH     = DEF_HOLD_WIDTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic       pin,
	input  bdlp_cfg_t  cfg,
	output bdlp_ev_t   ev
);

	localparam int DB_CMP_W   = (DEBOUNCE_WIDTH > DB_TICKS_WIDTH) ? DEBOUNCE_WIDTH
	                                                               : DB_TICKS_WIDTH;
	localparam int HOLD_CMP_W = (HOLD_WIDTH > LONG_TICKS_WIDTH) ? HOLD_WIDTH
	                                                            : LONG_TICKS_WIDTH;
	localparam logic [DEBOUNCE_WIDTH-1:0] DB_MAX   = {DEBOUNCE_WIDTH{1'b1}};
	localparam logic [HOLD_WIDTH-1:0]     HOLD_MAX = {HOLD_WIDTH{1'b1}};

	logic [DEBOUNCE_WIDTH-1:0] db_q, db_n, db_dec;
	logic [HOLD_WIDTH-1:0]     hold_q, hold_n, hold_inc;
	logic                      flag_q, flag_n;
	logic [DB_CMP_W-1:0]       db_x, dt_x;
	logic [HOLD_CMP_W-1:0]     hold_x, hold_inc_x, lt_x;

	always_comb begin
		db_x       = DB_CMP_W'(db_q);
		dt_x       = DB_CMP_W'(cfg.debounce_ticks);
		hold_x     = HOLD_CMP_W'(hold_q);
		lt_x       = HOLD_CMP_W'(cfg.long_ticks);
		hold_inc   = (hold_q == HOLD_MAX) ? hold_q : hold_q + 1'b1;
		hold_inc_x = HOLD_CMP_W'(hold_inc);
		db_dec     = (db_q != '0) ? db_q - 1'b1 : db_q;

		db_n   = db_q;
		hold_n = hold_q;
		flag_n = flag_q;
		ev     = '0;

		if (pin) begin
			if (db_x >= dt_x) begin
				flag_n = 1'b1;
				if (hold_x == lt_x) begin
					// threshold tick: only long-enabled buttons move on
					if (cfg.long_en) begin
						ev.long_hit = 1'b1;
						hold_n      = hold_inc;
						flag_n      = 1'b0;
					end
				end else begin
					hold_n = hold_inc;
					if (cfg.long_en && (hold_inc_x > lt_x)) begin
						flag_n        = 1'b0;
						ev.repeat_hit = cfg.repeat_en;
					end
				end
			end else begin
				db_n   = (db_q == DB_MAX) ? db_q : db_q + 1'b1;
				hold_n = '0;
			end
		end else begin
			db_n = db_dec;
			if (flag_q && (db_dec == '0)) begin
				flag_n       = 1'b0;
				ev.press_hit = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			db_q   <= '0;
			hold_q <= '0;
			flag_q <= 1'b0;
		end else if (step) begin
			db_q   <= db_n;
			hold_q <= hold_n;
			flag_q <= flag_n;
		end
	end

endmodule

// ===== tb/sv/tb_button_debounce_long_press.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_button_debounce_long_press
// self-checking bench: directed table, then press/release bursts or noise per button
// checked against an in-bench model of the debounce, hold and event logic
// ----------------------------------------------------------------------------
module tb_button_debounce_long_press;
	import bdlp_pkg::*;

	// ------------------------------------------------------------------------
	// bench constants
	// ------------------------------------------------------------------------
	localparam int STALL_LIMIT  = 2000;  // cycles with no transfer anywhere
	localparam int SETTLE_TICKS = 8;     // idle clocks after the last owed result
	localparam int PHASE_TICKS  = 20;    // ticks per random settings phase
	localparam int N_DIR        = 31;

	// an index that maps to no register, writes to it must be ignored
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_IDX_UNMAPPED = 8'hC7;

	// ------------------------------------------------------------------------
	// types
	// ------------------------------------------------------------------------
	// event bits of one tick, one bit per button
	typedef struct packed {
		logic [NUM_BUTTONS-1:0] press_ev;
		logic [NUM_BUTTONS-1:0] long_ev;
		logic [NUM_BUTTONS-1:0] rept_ev;
	} tick_events_t;

	typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_e;

	// one row of the directed table; known rows carry a hand-typed result
	typedef struct packed {
		row_kind_e                  kind;
		logic [CFG_INDEX_WIDTH-1:0] idx;
		logic [CFG_DATA_WIDTH-1:0]  data;
		logic [NUM_BUTTONS-1:0]     pins;
		logic                       known;
		tick_events_t               want;
	} stim_row_t;

	// ------------------------------------------------------------------------
	// dut signals, every input driven to a known value from time zero
	// ------------------------------------------------------------------------
	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       s_tvalid = 1'b0;
	logic                       s_tready;
	logic [S_TDATA_WIDTH-1:0]   s_tdata = '0;  // [3:0] pin_levels, rest zero
	logic                       m_tvalid;
	logic                       m_tready = 1'b0;
	logic [M_TDATA_WIDTH-1:0]   m_tdata;       // [3:0] press, [7:4] long,
	                                           // [11:8] repeat, rest zero
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
	logic [CFG_DATA_WIDTH-1:0]  cfg_data = '0;

	button_debounce_long_press u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// ------------------------------------------------------------------------
	// bench state
	// ------------------------------------------------------------------------
	// settings as the block should hold them
	logic [DB_TICKS_WIDTH-1:0]   deb_thr;
	logic [LONG_TICKS_WIDTH-1:0] long_thr;
	logic [NUM_BUTTONS-1:0]      long_mask;
	logic [NUM_BUTTONS-1:0]      rep_mask;

	// per-button counters and the debounced-down mark
	logic [DEF_DEBOUNCE_WIDTH-1:0] db_cnt    [NUM_BUTTONS];
	logic [DEF_HOLD_WIDTH-1:0]     hold_cnt  [NUM_BUTTONS];
	logic                          down_flag [NUM_BUTTONS];

	tick_events_t pending_events [$];  // event words owed by the block, oldest first
	tick_events_t due_events;

	int err_count    = 0;
	int stall_cycles = 0;
	int src_idle_pct = 0;  // chance per cycle that the sender holds off
	int snk_idle_pct = 0;  // chance per cycle that the receiver stalls

	// burst generator: current level and ticks left in it, per button
	logic seg_level [NUM_BUTTONS];
	int   seg_left  [NUM_BUTTONS];

	// directed table: reset defaults, zero thresholds, then a small setting
	stim_row_t dir_rows [N_DIR] = '{
		// right after reset nothing can be debounced yet
		'{ROW_TICK,  '0, '0, 4'hF, 1'b1, '{4'h0, 4'h0, 4'h0}},
		'{ROW_TICK,  '0, '0, 4'h0, 1'b1, '{4'h0, 4'h0, 4'h0}},
		// zero debounce and zero long threshold, upper data bits must drop
		'{ROW_WRITE, REG_DEBOUNCE_TICKS,     16'hA500, 4'h0, 1'b0, '0},
		'{ROW_WRITE, REG_LONG_TICKS,         16'h0000, 4'h0, 1'b0, '0},
		'{ROW_WRITE, REG_LONG_ENABLE_MASK,   16'hFFF5, 4'h0, 1'b0, '0},
		'{ROW_WRITE, REG_REPEAT_ENABLE_MASK, 16'h0004, 4'h0, 1'b0, '0},
		'{ROW_WRITE, CFG_IDX_UNMAPPED,       16'hFFFF, 4'h0, 1'b0, '0},
		// long fires on the first accepted tick for the long-enabled buttons
		'{ROW_TICK,  '0, '0, 4'hF, 1'b1, '{4'h0, 4'h5, 4'h0}},
		// repeat on the next held tick where enabled
		'{ROW_TICK,  '0, '0, 4'hF, 1'b1, '{4'h0, 4'h0, 4'h4}},
		// buttons without long enable give a short press on release
		'{ROW_TICK,  '0, '0, 4'h0, 1'b1, '{4'hA, 4'h0, 4'h0}},
		'{ROW_TICK,  '0, '0, 4'h0, 1'b1, '{4'h0, 4'h0, 4'h0}},
		'{ROW_WRITE, REG_DEBOUNCE_TICKS,     16'h0002, 4'h0, 1'b0, '0},
		'{ROW_WRITE, REG_LONG_TICKS,         16'h0001, 4'h0, 1'b0, '0},
		'{ROW_WRITE, REG_LONG_ENABLE_MASK,   16'h0003, 4'h0, 1'b0, '0},
		'{ROW_WRITE, REG_REPEAT_ENABLE_MASK, 16'h0001, 4'h0, 1'b0, '0},
		'{ROW_TICK,  '0, '0, 4'hF, 1'b0, '0},
		'{ROW_TICK,  '0, '0, 4'hF, 1'b0, '0},
		'{ROW_TICK,  '0, '0, 4'hF, 1'b0, '0},
		'{ROW_TICK,  '0, '0, 4'hF, 1'b0, '0},
		'{ROW_TICK,  '0, '0, 4'hF, 1'b0, '0},
		'{ROW_TICK,  '0, '0, 4'h5, 1'b0, '0},
		'{ROW_TICK,  '0, '0, 4'h0, 1'b0, '0},
		'{ROW_TICK,  '0, '0, 4'h0, 1'b0, '0},
		'{ROW_TICK,  '0, '0, 4'hA, 1'b0, '0},
		'{ROW_TICK,  '0, '0, 4'h0, 1'b0, '0},
		'{ROW_TICK,  '0, '0, 4'hA, 1'b0, '0},
		'{ROW_TICK,  '0, '0, 4'hA, 1'b0, '0},
		'{ROW_TICK,  '0, '0, 4'hA, 1'b0, '0},
		'{ROW_TICK,  '0, '0, 4'h0, 1'b0, '0},
		'{ROW_TICK,  '0, '0, 4'h0, 1'b0, '0},
		'{ROW_TICK,  '0, '0, 4'h0, 1'b0, '0}
	};

	// ------------------------------------------------------------------------
	// model of the block
	// ------------------------------------------------------------------------
	// hold counter saturates at all ones instead of wrapping
	function automatic logic [DEF_HOLD_WIDTH-1:0] hold_step(logic [DEF_HOLD_WIDTH-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	// one sampling tick: advance every button and collect its events
	function automatic tick_events_t debounce_tick(logic [NUM_BUTTONS-1:0] pins);
		tick_events_t ev;
		ev = '0;
		for (int b = 0; b < NUM_BUTTONS; b++) begin
			if (pins[b]) begin
				if (db_cnt[b] >= deb_thr) begin
					down_flag[b] = 1'b1;
					if (hold_cnt[b] == long_thr) begin
						// without long enable the hold counter parks here
						if (long_mask[b]) begin
							ev.long_ev[b] = 1'b1;
							hold_cnt[b]   = hold_step(hold_cnt[b]);
							down_flag[b]  = 1'b0;
						end
					end else begin
						hold_cnt[b] = hold_step(hold_cnt[b]);
						if (long_mask[b] && hold_cnt[b] > long_thr) begin
							down_flag[b] = 1'b0;
							if (rep_mask[b])
								ev.rept_ev[b] = 1'b1;
						end
					end
				end else begin
					if (db_cnt[b] != '1)
						db_cnt[b] = db_cnt[b] + 1'b1;
					hold_cnt[b] = '0;
				end
			end else begin
				if (db_cnt[b] != '0)
					db_cnt[b] = db_cnt[b] - 1'b1;
				// a short press is reported once the integrator has drained
				if (down_flag[b] && db_cnt[b] == '0) begin
					down_flag[b]   = 1'b0;
					ev.press_ev[b] = 1'b1;
				end
			end
		end
		return ev;
	endfunction

	// ------------------------------------------------------------------------
	// burst stimulus: per-button presses and releases sized around the
	// current thresholds, with some contact bounce on top
	// ------------------------------------------------------------------------
	function automatic int burst_len(logic pressed);
		int d;
		int l;
		d = int'(deb_thr);
		l = int'(long_thr);
		if (pressed) begin
			case ($urandom_range(0, 3))
				0:       return $urandom_range(1, d + 1);          // at most just long enough to count
				3:       return $urandom_range(d + 1, d + l + 1);  // short press, long at the top end
				default: return $urandom_range(d + l + 1, d + l + 5);  // long, repeats
			endcase
		end
		if ($urandom_range(0, 3) == 0)
			return $urandom_range(1, 2);  // bounce gap
		return $urandom_range(d, d + 3);
	endfunction

	function automatic logic [NUM_BUTTONS-1:0] next_pins(bit noisy);
		logic [NUM_BUTTONS-1:0] pins;
		if (noisy)
			return NUM_BUTTONS'($urandom_range(0, (1 << NUM_BUTTONS) - 1));
		for (int b = 0; b < NUM_BUTTONS; b++) begin
			if (seg_left[b] <= 0) begin
				seg_level[b] = ~seg_level[b];
				seg_left[b]  = burst_len(seg_level[b]);
			end
			seg_left[b]--;
			pins[b] = seg_level[b] ^ ($urandom_range(0, 99) < 6);
		end
		return pins;
	endfunction

	// ------------------------------------------------------------------------
	// driving tasks
	// ------------------------------------------------------------------------
	// offer one tick, wait for its transfer, then book its expected events
	task automatic send_tick(logic [NUM_BUTTONS-1:0] pins, bit known,
	                         tick_events_t want);
		tick_events_t ev;
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= S_TDATA_WIDTH'(pins);
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		ev = debounce_tick(pins);
		pending_events.push_back(known ? want : ev);
	endtask

	// stop offering ticks and let every owed result come out
	task automatic drain;
		s_tvalid <= 1'b0;
		while (pending_events.size() != 0)
			@(posedge clk);
		repeat (SETTLE_TICKS) @(posedge clk);
	endtask

	// one register write; cfg_valid is lowered by the caller after a group
	task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] idx,
	                         logic [CFG_DATA_WIDTH-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_DEBOUNCE_TICKS:     deb_thr   = data[DB_TICKS_WIDTH-1:0];
			REG_LONG_TICKS:         long_thr  = data[LONG_TICKS_WIDTH-1:0];
			REG_LONG_ENABLE_MASK:   long_mask = data[NUM_BUTTONS-1:0];
			REG_REPEAT_ENABLE_MASK: rep_mask  = data[NUM_BUTTONS-1:0];
			default: ;
		endcase
	endtask

	// full settings change between phases; junk in the unused data bits
	// and a stray write to an unmapped index must have no effect
	task automatic apply_settings(int deb, int lng, int lm, int rm);
		drain();
		write_reg(REG_DEBOUNCE_TICKS,
		          {CFG_DATA_WIDTH'($urandom) >> DB_TICKS_WIDTH << DB_TICKS_WIDTH}
		          | CFG_DATA_WIDTH'(deb));
		write_reg(REG_LONG_TICKS, CFG_DATA_WIDTH'(lng));
		write_reg(REG_LONG_ENABLE_MASK,
		          {CFG_DATA_WIDTH'($urandom) >> NUM_BUTTONS << NUM_BUTTONS}
		          | CFG_DATA_WIDTH'(lm));
		write_reg(REG_REPEAT_ENABLE_MASK,
		          {CFG_DATA_WIDTH'($urandom) >> NUM_BUTTONS << NUM_BUTTONS}
		          | CFG_DATA_WIDTH'(rm));
		write_reg(CFG_INDEX_WIDTH'($urandom_range(int'(REG_REPEAT_ENABLE_MASK) + 1,
		                                          (1 << CFG_INDEX_WIDTH) - 1)),
		          CFG_DATA_WIDTH'($urandom));
		cfg_valid <= 1'b0;
	endtask

	// a phase of bursts starts from all buttons released
	task automatic run_phase(int n_ticks, bit noisy);
		for (int b = 0; b < NUM_BUTTONS; b++) begin
			seg_level[b] = 1'b0;
			seg_left[b]  = burst_len(1'b0);
		end
		for (int i = 0; i < n_ticks; i++)
			send_tick(next_pins(noisy), 1'b0, '0);
	endtask

	// ------------------------------------------------------------------------
	// mismatch reporting
	// ------------------------------------------------------------------------
	task automatic report_mismatch(string what, logic [NUM_BUTTONS-1:0] got,
	                               logic [NUM_BUTTONS-1:0] want);
		$display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
		err_count++;
	endtask

	// ------------------------------------------------------------------------
	// clock
	// ------------------------------------------------------------------------
	initial begin
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// result side: compare each transfer with the oldest owed event word,
	// then pick the stall for the next cycle
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (pending_events.size() == 0) begin
				report_mismatch("result with nothing pending", m_tdata[3:0], '0);
			end else begin
				due_events = pending_events.pop_front();
				if (m_tdata[3:0] !== due_events.press_ev)
					report_mismatch("press_events", m_tdata[3:0], due_events.press_ev);
				if (m_tdata[7:4] !== due_events.long_ev)
					report_mismatch("long_events", m_tdata[7:4], due_events.long_ev);
				if (m_tdata[11:8] !== due_events.rept_ev)
					report_mismatch("repeat_events", m_tdata[11:8], due_events.rept_ev);
			end
		end
		m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
	end

	// ------------------------------------------------------------------------
	// watchdog: a run that moves nothing for too long has hung
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------
	initial begin
		bit in_cfg;
		in_cfg = 1'b0;

		// model starts from the reset defaults and cleared counters
		deb_thr   = RST_DEBOUNCE_TICKS;
		long_thr  = RST_LONG_TICKS;
		long_mask = RST_LONG_ENABLE_MASK;
		rep_mask  = RST_REPEAT_ENABLE_MASK;
		for (int b = 0; b < NUM_BUTTONS; b++) begin
			db_cnt[b]    = '0;
			hold_cnt[b]  = '0;
			down_flag[b] = 1'b0;
		end

		// sender mostly busy, receiver mostly stalling
		src_idle_pct = 12;
		snk_idle_pct = 77;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed table; a run of writes only starts once the block is idle
		for (int r = 0; r < N_DIR; r++) begin
			if (dir_rows[r].kind == ROW_WRITE) begin
				if (!in_cfg) begin
					drain();
					in_cfg = 1'b1;
				end
				write_reg(dir_rows[r].idx, dir_rows[r].data);
			end else begin
				if (in_cfg) begin
					cfg_valid <= 1'b0;
					in_cfg = 1'b0;
				end
				send_tick(dir_rows[r].pins, dir_rows[r].known, dir_rows[r].want);
			end
		end

		// three idling stages, four settings phases each; the last phase of
		// a stage is pure noise, the rest are press/release bursts
		for (int stage = 0; stage < 3; stage++) begin
			case (stage)
				0:       begin src_idle_pct = 12; snk_idle_pct = 77; end
				1:       begin src_idle_pct = 77; snk_idle_pct = 12; end
				default: begin src_idle_pct = 0;  snk_idle_pct = 0;  end
			endcase
			for (int p = 0; p < 4; p++) begin
				if (p == 0 && stage == 0)
					apply_settings($urandom_range(1, 6), $urandom_range(0, 12), 15, 15);
				else if (p == 0 && stage == 1)
					apply_settings($urandom_range(1, 6), $urandom_range(0, 12), 0, 0);
				else
					apply_settings($urandom_range(0, 6), $urandom_range(0, 12),
					               $urandom_range(0, 15), $urandom_range(0, 15));
				run_phase(PHASE_TICKS, p == 3);
			end
		end

		// extremes: slowest debounce and the largest long threshold; the
		// integrator climbs all the way to its top before the press is
		// accepted, and a short release then only starts to drain it
		apply_settings((1 << DB_TICKS_WIDTH) - 1, (1 << LONG_TICKS_WIDTH) - 1, 3, 1);
		for (int i = 0; i < (1 << DB_TICKS_WIDTH) + 8; i++)
			send_tick({NUM_BUTTONS{1'b1}}, 1'b0, '0);
		for (int i = 0; i < 16; i++)
			send_tick('0, 1'b0, '0);

		drain();
		if (err_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
